/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cfd_pkg.sv */
// ----------------------------------------------------------------------------
// Frame deframer package
// Shared types, codes and the byte-wise CRC-32 update.
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam int LEN_WIDTH  = 32;
  localparam int HDR_BYTES  = 20;
  localparam int HDR_CNT_W  = 5;
  localparam int CMP_W      = 33;
  localparam int CRC_BYTES  = 4;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [31:0] MAGIC_RESET   = 32'd827608659;
  localparam logic [7:0]  VERSION_RESET = 8'd1;
  localparam logic [31:0] MAXLEN_RESET  = 32'd65536;

  localparam logic [1:0] REG_MAGIC   = 2'd0;
  localparam logic [1:0] REG_VERSION = 2'd1;
  localparam logic [1:0] REG_MAXLEN  = 2'd2;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_CRC     = 2'd2;
  localparam logic [1:0] PH_UNUSED  = 2'd3;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC   = 3'd1;
  localparam logic [2:0] ST_BAD_VERSION = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE   = 3'd3;
  localparam logic [2:0] ST_CRC_BAD     = 3'd4;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [7:0]  expected_version;
    logic [31:0] max_payload_len;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [7:0]  packet_type;
    logic [15:0] frame_flags;
    logic [63:0] handle;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last;
  } res_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/core/cfd_parser.sv */
// ----------------------------------------------------------------------------
// Frame parser
// Header gather and checks, payload pass-through, CRC-32 track and compare.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfd_parser import cfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output res_t       res
);

  logic [1:0]           phase, phase_next;
  logic [LEN_WIDTH-1:0] byte_count, byte_count_next;
  logic [31:0]          running_crc, running_crc_next;
  logic [31:0]          magic_seen, magic_seen_next;
  logic [7:0]           version_seen, version_seen_next;
  logic [7:0]           type_seen, type_seen_next;
  logic [15:0]          flags_seen, flags_seen_next;
  logic [63:0]          handle_seen, handle_seen_next;
  logic [31:0]          length_seen, length_seen_next;
  logic [31:0]          received_crc, received_crc_next;

  logic [HDR_CNT_W-1:0] hdr_idx;
  logic [LEN_WIDTH:0]   cnt_inc;
  logic [31:0]          crc_upd;
  logic [2:0]           hdr_status;
  logic [1:0]           res_kind;
  logic [2:0]           res_status;
  logic [7:0]           res_pbyte;

  assign crc_upd = crc32_byte(running_crc, rx_byte);
  assign cnt_inc = {1'b0, byte_count} + {{LEN_WIDTH{1'b0}}, 1'b1};
  assign hdr_idx = (byte_count >= LEN_WIDTH'(HDR_BYTES)) ? '0
                                                         : byte_count[HDR_CNT_W-1:0];

  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    running_crc_next  = running_crc;
    magic_seen_next   = magic_seen;
    version_seen_next = version_seen;
    type_seen_next    = type_seen;
    flags_seen_next   = flags_seen;
    handle_seen_next  = handle_seen;
    length_seen_next  = length_seen;
    received_crc_next = received_crc;
    hdr_status        = ST_OK;
    res_valid         = 1'b0;
    res_kind          = KIND_HEADER;
    res_status        = ST_OK;
    res_pbyte         = 8'd0;
    case (phase)
      PH_PAYLOAD: begin
        running_crc_next = crc_upd;
        byte_count_next  = cnt_inc[LEN_WIDTH-1:0];
        if (CMP_W'(cnt_inc) >= CMP_W'(length_seen)) begin
          phase_next        = PH_CRC;
          byte_count_next   = '0;
          received_crc_next = '0;
        end
        res_valid = 1'b1;
        res_kind  = KIND_PAYLOAD;
        res_pbyte = rx_byte;
      end
      PH_CRC: begin
        received_crc_next[8*byte_count[1:0] +: 8] = rx_byte;
        byte_count_next = cnt_inc[LEN_WIDTH-1:0];
        if (CMP_W'(cnt_inc) >= CMP_W'(CRC_BYTES)) begin
          res_valid         = 1'b1;
          res_kind          = KIND_END;
          res_status        = ((running_crc ^ CRC_INIT) == received_crc_next) ? ST_OK
                                                                              : ST_CRC_BAD;
          phase_next        = PH_HEADER;
          byte_count_next   = '0;
          running_crc_next  = CRC_INIT;
          received_crc_next = '0;
        end
      end
      default: begin
        phase_next       = PH_HEADER;
        running_crc_next = crc_upd;
        if (hdr_idx < HDR_CNT_W'(4)) begin
          magic_seen_next[8*hdr_idx[1:0] +: 8] = rx_byte;
        end else if (hdr_idx == HDR_CNT_W'(4)) begin
          version_seen_next = rx_byte;
        end else if (hdr_idx == HDR_CNT_W'(5)) begin
          type_seen_next = rx_byte;
        end else if (hdr_idx < HDR_CNT_W'(8)) begin
          flags_seen_next[8*hdr_idx[0] +: 8] = rx_byte;
        end else if (hdr_idx < HDR_CNT_W'(16)) begin
          handle_seen_next[8*hdr_idx[2:0] +: 8] = rx_byte;
        end else begin
          length_seen_next[8*hdr_idx[1:0] +: 8] = rx_byte;
        end
        byte_count_next = LEN_WIDTH'(hdr_idx + HDR_CNT_W'(1));
        if (hdr_idx == HDR_CNT_W'(HDR_BYTES - 1)) begin
          if (magic_seen_next != cfg.magic_word) begin
            hdr_status = ST_BAD_MAGIC;
          end else if (version_seen_next != cfg.expected_version) begin
            hdr_status = ST_BAD_VERSION;
          end else if ((length_seen_next > cfg.max_payload_len) ||
                       (|(length_seen_next >> LEN_WIDTH))) begin
            hdr_status = ST_TOO_LARGE;
          end
          res_valid         = 1'b1;
          byte_count_next   = '0;
          received_crc_next = '0;
          if (hdr_status != ST_OK) begin
            res_kind         = KIND_END;
            res_status       = hdr_status;
            running_crc_next = CRC_INIT;
          end else begin
            res_kind   = KIND_HEADER;
            phase_next = (length_seen_next == 32'd0) ? PH_CRC : PH_PAYLOAD;
          end
        end
      end
    endcase
  end

  always_comb begin
    res.kind           = res_kind;
    res.status         = res_status;
    res.packet_type    = type_seen_next;
    res.frame_flags    = flags_seen_next;
    res.handle         = handle_seen_next;
    res.payload_length = length_seen_next;
    res.payload_byte   = res_pbyte;
    res.last           = (res_kind == KIND_END);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      byte_count   <= '0;
      running_crc  <= CRC_INIT;
      magic_seen   <= '0;
      version_seen <= '0;
      type_seen    <= '0;
      flags_seen   <= '0;
      handle_seen  <= '0;
      length_seen  <= '0;
      received_crc <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      running_crc  <= running_crc_next;
      magic_seen   <= magic_seen_next;
      version_seen <= version_seen_next;
      type_seen    <= type_seen_next;
      flags_seen   <= flags_seen_next;
      handle_seen  <= handle_seen_next;
      length_seen  <= length_seen_next;
      received_crc <= received_crc_next;
    end
  end

  `ASSERT_ALWAYS(a_phase_reachable, phase != PH_UNUSED, "parser entered unused phase")
  `ASSERT_ALWAYS(a_payload_count, (phase != PH_PAYLOAD) ||
                 (CMP_W'(byte_count) < CMP_W'(length_seen)), "payload count overran length")
  `ASSERT_ALWAYS(a_crc_count, (phase != PH_CRC) || (byte_count < LEN_WIDTH'(CRC_BYTES)),
                 "crc byte count overran")

endmodule

/* rtl/core/crc32_frame_deframer.sv */
// ----------------------------------------------------------------------------
// CRC-32 frame deframer
// Parses length-prefixed frames from a byte stream and checks the CRC-32.
// ----------------------------------------------------------------------------
// Each result is registered, in the output register or, when stalled, in the skid.
// Throughput: one byte per cycle while in_stall is low; the parser updates in a single pass per byte.
// A two-entry output stage (register plus skid) absorbs one result of stall.
// Reset: synchronous; parser returns to header hunt, registers take defaults.
`include "assert_macros.svh"

module crc32_frame_deframer import cfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [2:0]  status,
  output logic [7:0]  packet_type,
  output logic [15:0] frame_flags,
  output logic [63:0] handle,
  output logic [31:0] payload_length,
  output logic [7:0]  payload_byte,
  output logic        last
);

  cfg_t cfg;
  logic accept;
  logic res_valid;
  res_t res;
  res_t out_word;
  res_t skid_word;
  logic skid_valid;
  logic out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_word       <= MAGIC_RESET;
      cfg.expected_version <= VERSION_RESET;
      cfg.max_payload_len  <= MAXLEN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAGIC:   cfg.magic_word       <= cfg_data;
        REG_VERSION: cfg.expected_version <= cfg_data[7:0];
        REG_MAXLEN:  cfg.max_payload_len  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign out_free = !out_valid || !out_stall;

  cfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // advance from skid first, otherwise take the new result; hold when stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept && res_valid;
      end
    end else if (accept && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_word <= skid_valid ? skid_word : res;
    end
    if (!out_free && !skid_valid) begin
      skid_word <= res;
    end
  end

  assign kind           = out_word.kind;
  assign status         = out_word.status;
  assign packet_type    = out_word.packet_type;
  assign frame_flags    = out_word.frame_flags;
  assign handle         = out_word.handle;
  assign payload_length = out_word.payload_length;
  assign payload_byte   = out_word.payload_byte;
  assign last           = out_word.last;

  `ASSERT_ALWAYS(a_skid_behind_out, !skid_valid || out_valid, "skid holds word with empty output")
  `ASSERT_NEXT(a_skid_drains, skid_valid && !out_stall, !skid_valid, "skid failed to drain")

endmodule
